/* src/ttu_pkg.sv */
// Shared constants, types and helpers for the Taylor trig unit.
`timescale 1ns / 1ps
package ttu_pkg;

  localparam int WORK_FRAC        = 40;
  localparam int ANGLE_FRAC_DEF   = 24;
  localparam int RESULT_FRAC_DEF  = 30;
  localparam int RES_W            = 48;
  localparam int EPS_W            = 30;
  localparam int MAXT_W           = 6;

  localparam logic signed [63:0] TWO_PI_W = 64'sh6487ED5110B;
  localparam logic signed [63:0] PI_W     = 64'sh3243F6A8886;
  localparam logic signed [48:0] ONE_W    = 49'sh1_0000_0000_00;

  localparam logic [1:0] FUNC_SIN = 2'd0;
  localparam logic [1:0] FUNC_COS = 2'd1;
  localparam logic [1:0] FUNC_TAN = 2'd2;
  localparam logic [1:0] FUNC_COT = 2'd3;

  localparam logic CFG_EPSILON   = 1'b0;
  localparam logic CFG_MAX_TERMS = 1'b1;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Saturating pack of a sign and magnitude into the 48-bit two's-complement result.
  function automatic logic [RES_W-1:0] pack(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    logic [63:0] mm;
    lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    mm  = (m > lim) ? lim : m;
    pack = neg ? RES_W'(64'(-mm)) : RES_W'(mm);
  endfunction

endpackage

/* src/ttu_mul.sv */
// Shared 48x48 multiplier that sums four 24x24 partial products in turn.
`timescale 1ns / 1ps
module ttu_mul import ttu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  unit_ctrl_t   ctrl,
  input  logic [47:0]  a,
  input  logic [47:0]  b,
  output unit_stat_t   stat,
  output logic [95:0]  prod
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [47:0] a_r, a_nxt, b_r, b_nxt;
  logic [95:0] acc_r, acc_nxt;

  logic [23:0] ah, bh;
  logic [47:0] pp;
  logic [6:0]  sh;

  always_comb begin
    ah = step_r[1] ? a_r[47:24] : a_r[23:0];
    bh = step_r[0] ? b_r[47:24] : b_r[23:0];
    pp = 48'(ah) * 48'(bh);
    sh = 7'(24 * (32'(step_r[1]) + 32'(step_r[0])));
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (ctrl.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + (96'(pp) << sh);
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

/* src/ttu_div.sv */
// Bit-serial restoring divider for the tangent and cotangent quotient, saturating at 49 bits.
`timescale 1ns / 1ps
module ttu_div import ttu_pkg::*; #(
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  unit_ctrl_t  ctrl,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output unit_stat_t  stat,
  output logic [48:0] quo
);

  localparam int NW  = 64 + RESULT_FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [63:0]   den_r, den_nxt;
  logic [63:0]   rem_r, rem_nxt;
  logic [48:0]   q_r, q_nxt;
  logic [64:0]   r2;

  always_comb begin
    r2       = {rem_r, dvd_r[NW-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (ctrl.start && !busy_r) begin
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      dvd_nxt  = {num, {RESULT_FRAC_BITS{1'b0}}};
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      if (q_r[48]) ovf_nxt = 1'b1;
      if (r2 >= {1'b0, den_r}) begin
        rem_nxt = 64'(r2 - {1'b0, den_r});
        q_nxt   = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = r2[63:0];
        q_nxt   = {q_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ovf_r <= ovf_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = ovf_r ? '1 : q_r;

endmodule

/* src/taylor_trig_unit_top.sv */
// Top level of the Taylor-series sine, cosine, tangent and cotangent unit.
//
//  channel   ports                                    beat taken when
//  --------  ---------------------------------------  ----------------------
//  input     start, busy, in_func, in_angle           start & !busy
//  result    out_valid, out_result, out_undefined     out_valid (one cycle)
//  config    cfg_we, cfg_index, cfg_wdata             cfg_we
//
// Reduction adds or subtracts 2*pi per step until the angle lies in (-pi,
// pi], then the square, then each series term as a shared multiply plus a
// radix-16 divide by the term constant. Tangent/cotangent runs both series
// then a bit-serial quotient. One beat at a time; busy is high throughout.
// Synchronous active-low reset restores epsilon 1, max_terms 16.
// The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module taylor_trig_unit_top import ttu_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic signed [31:0]      in_angle,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] out_result,
  output logic                    out_undefined,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [EPS_W-1:0]        cfg_wdata
);

  localparam int XSH = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int RSH = WORK_FRAC - RESULT_FRAC_BITS;
  localparam int TDIV_LAST = 48 / 4 - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_SQ_WAIT, S_SER_INIT, S_TERM_CHK,
    S_MUL_WAIT, S_TDIV, S_SER_DONE, S_Q_WAIT
  } state_t;

  state_t state_r, state_nxt;

  logic [EPS_W-1:0]        eps_r, eps_nxt;
  logic [MAXT_W-1:0]       maxt_r, maxt_nxt;
  logic [1:0]              func_r, func_nxt;
  logic signed [63:0]      x_r, x_nxt;
  logic [47:0]             x2_r, x2_nxt;
  logic                    sine_r, sine_nxt;
  logic signed [48:0]      term_r, term_nxt;
  logic signed [63:0]      sum_r, sum_nxt;
  logic signed [63:0]      s_r, s_nxt;
  logic [MAXT_W-1:0]       n_r, n_nxt;
  logic [13:0]             d_r, d_nxt;
  logic [47:0]             dvd_r, dvd_nxt;
  logic [13:0]             rem_r, rem_nxt;
  logic [3:0]              tcnt_r, tcnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]        out_result_r, out_result_nxt;
  logic                    out_undef_r, out_undef_nxt;

  unit_ctrl_t  mul_ctrl, div_ctrl;
  unit_stat_t  mul_stat, div_stat;
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_prod;
  logic [63:0] div_num, div_den;
  logic [48:0] div_quo;

  logic [63:0] eps_w;
  logic [63:0] x_mag;
  logic [48:0] term_abs;
  logic [47:0] term_mag;
  logic [6:0]  k;
  logic [13:0] d_calc;
  logic [14:0] r2;
  logic [13:0] rem_t;
  logic [47:0] dvd_t;
  logic [63:0] sum_mag, sum_rnd;
  logic signed [63:0] num_v, den_v;

  ttu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mul_ctrl),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  ttu_div #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_comb begin
    eps_w    = {24'd0, eps_r, 10'd0};
    x_mag    = mag64(x_r);
    term_abs = term_r[48] ? 49'(-term_r) : 49'(term_r);
    term_mag = term_abs[47:0];
    k        = {n_r, 1'b0};
    d_calc   = sine_r ? 14'(k) * (14'(k) + 14'd1) : (14'(k) - 14'd1) * 14'(k);
    sum_mag  = mag64(sum_r);
    sum_rnd  = (sum_mag + ((64'd1 << RSH) >> 1)) >> RSH;
    num_v    = (func_r == FUNC_TAN) ? s_r : sum_r;
    den_v    = (func_r == FUNC_TAN) ? sum_r : s_r;

    // radix-16 step of the term divide: four restoring steps on narrow values
    rem_t = rem_r;
    dvd_t = dvd_r;
    for (int i = 0; i < 4; i++) begin
      r2    = {rem_t, dvd_t[47]};
      dvd_t = {dvd_t[46:0], 1'b0};
      if (r2 >= {1'b0, d_r}) begin
        rem_t    = 14'(r2 - {1'b0, d_r});
        dvd_t[0] = 1'b1;
      end else begin
        rem_t = r2[13:0];
      end
    end

    state_nxt      = state_r;
    eps_nxt        = eps_r;
    maxt_nxt       = maxt_r;
    func_nxt       = func_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    sine_nxt       = sine_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    s_nxt          = s_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    tcnt_nxt       = tcnt_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    out_undef_nxt  = out_undef_r;
    mul_ctrl.start = 1'b0;
    mul_a          = term_mag;
    mul_b          = x2_r;
    div_ctrl.start = 1'b0;
    div_num        = mag64(num_v);
    div_den        = mag64(den_v);

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_EPSILON:   eps_nxt  = cfg_wdata;
        CFG_MAX_TERMS: maxt_nxt = cfg_wdata[MAXT_W-1:0];
        default:       ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          x_nxt     = {{32{in_angle[31]}}, in_angle} <<< XSH;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (x_r > PI_W) begin
          x_nxt = x_r - TWO_PI_W;
        end else if (x_r <= -PI_W) begin
          x_nxt = x_r + TWO_PI_W;
        end else begin
          mul_ctrl.start = 1'b1;
          mul_a          = x_mag[47:0];
          mul_b          = x_mag[47:0];
          state_nxt      = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (mul_stat.done) begin
          x2_nxt    = mul_prod[WORK_FRAC +: 48];
          sine_nxt  = (func_r != FUNC_COS);
          state_nxt = S_SER_INIT;
        end
      end
      S_SER_INIT: begin
        term_nxt  = sine_r ? x_r[48:0] : ONE_W;
        sum_nxt   = sine_r ? x_r : 64'(ONE_W);
        n_nxt     = MAXT_W'(1);
        state_nxt = S_TERM_CHK;
      end
      S_TERM_CHK: begin
        if ((64'(term_mag) > eps_w) && (n_r < maxt_r)) begin
          mul_ctrl.start = 1'b1;
          d_nxt          = d_calc;
          state_nxt      = S_MUL_WAIT;
        end else begin
          state_nxt = S_SER_DONE;
        end
      end
      S_MUL_WAIT: begin
        if (mul_stat.done) begin
          dvd_nxt   = mul_prod[WORK_FRAC +: 48];
          rem_nxt   = '0;
          tcnt_nxt  = '0;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        dvd_nxt  = dvd_t;
        rem_nxt  = rem_t;
        tcnt_nxt = tcnt_r + 4'd1;
        if (tcnt_r == 4'(TDIV_LAST)) begin
          // alternate sign against the previous term
          term_nxt  = term_r[48] ? $signed({1'b0, dvd_t}) : -$signed({1'b0, dvd_t});
          sum_nxt   = sum_r + 64'(term_nxt);
          n_nxt     = n_r + MAXT_W'(1);
          state_nxt = S_TERM_CHK;
        end
      end
      S_SER_DONE: begin
        if (func_r == FUNC_SIN || func_r == FUNC_COS) begin
          out_result_nxt = pack(sum_r[63], sum_rnd);
          out_undef_nxt  = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sine_r) begin
          s_nxt     = sum_r;
          sine_nxt  = 1'b0;
          state_nxt = S_SER_INIT;
        end else if (den_v == 64'sd0 || mag64(den_v) < eps_w) begin
          out_result_nxt = '0;
          out_undef_nxt  = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          div_ctrl.start = 1'b1;
          neg_nxt        = num_v[63] ^ den_v[63];
          state_nxt      = S_Q_WAIT;
        end
      end
      S_Q_WAIT: begin
        if (div_stat.done) begin
          out_result_nxt = pack(neg_r, 64'(div_quo));
          out_undef_nxt  = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eps_r       <= EPS_W'(1);
      maxt_r      <= MAXT_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eps_r       <= eps_nxt;
      maxt_r      <= maxt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    x_r          <= x_nxt;
    x2_r         <= x2_nxt;
    sine_r       <= sine_nxt;
    term_r       <= term_nxt;
    sum_r        <= sum_nxt;
    s_r          <= s_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    tcnt_r       <= tcnt_nxt;
    neg_r        <= neg_nxt;
    out_result_r <= out_result_nxt;
    out_undef_r  <= out_undef_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_undefined = out_undef_r;

  // a result beat only follows work in progress
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result beat without work");

  // undefined results are forced to zero
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined) |-> (out_result == '0)) else $error("undefined result not zero");

  // sine and cosine never flag undefined
  a_sincos_def: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (func_r == FUNC_SIN || func_r == FUNC_COS)) |-> !out_undefined)
    else $error("undefined on sine or cosine");

  // the shared units are only seen busy while the sequencer is
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_stat.busy || div_stat.busy) |-> busy) else $error("unit busy while idle");

endmodule
